[rtl/edge_truncated_neighbor_blur_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the neighbor blur block
// Concurrent assertion wrappers. Define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef EDGE_TRUNCATED_NEIGHBOR_BLUR_TOP_MACROS_SVH
`define EDGE_TRUNCATED_NEIGHBOR_BLUR_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge outside reset
`define ETB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every rising edge, reset included
`define ETB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ETB_ASSERT(lbl, clk, rst_n, prop)
`define ETB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/etb_pkg.sv]
// ----------------------------------------------------------------------------
// etb_pkg
// Shared types and constants of the neighbor blur block.
// ----------------------------------------------------------------------------
package etb_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_OUT_W  = 12;
    localparam int COL_OUT_W  = 10;
    localparam int SUM_W      = 12;
    localparam int WEIGHT_W   = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam int NUM_BANKS   = 3;
    localparam int NUM_EMIT    = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix;

    // [row][col]: row 0 is the oldest line, col 0 the oldest column
    typedef t_pix [2:0][2:0] t_win;

    // Results one input can trigger, in emission order
    typedef enum logic [1:0] {
        EM_PREV_ROW_PREV_COL = 2'd0,
        EM_PREV_ROW_LAST     = 2'd1,
        EM_LAST_ROW_PREV_COL = 2'd2,
        EM_LAST_ROW_LAST     = 2'd3
    } t_emit;

    typedef struct packed {
        logic [NUM_EMIT-1:0]  emit_mask;
        logic                 row_is_one;
        logic                 col_is_one;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
    } t_job_info;

    typedef struct packed {
        t_win      win;
        t_job_info info;
    } t_job;

endpackage

[rtl/etb_if.sv]
// ----------------------------------------------------------------------------
// etb_if
// Valid/ready channels of the neighbor blur block.
// ----------------------------------------------------------------------------
interface etb_pix_if;
    logic                      valid;
    logic                      ready;
    logic [etb_pkg::PIX_W-1:0] red_in;
    logic [etb_pkg::PIX_W-1:0] green_in;
    logic [etb_pkg::PIX_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface etb_res_if;
    logic                         valid;
    logic                         ready;
    logic [etb_pkg::ROW_OUT_W-1:0] out_row;
    logic [etb_pkg::COL_OUT_W-1:0] out_col;
    logic [etb_pkg::SUM_W-1:0]     red_sum;
    logic [etb_pkg::SUM_W-1:0]     green_sum;
    logic [etb_pkg::SUM_W-1:0]     blue_sum;
    logic [etb_pkg::WEIGHT_W-1:0]  total_weight;
    logic                          last_of_run;

    modport source (output valid, output out_row, output out_col, output red_sum,
                    output green_sum, output blue_sum, output total_weight,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input red_sum,
                    input green_sum, input blue_sum, input total_weight,
                    input last_of_run, output ready);
endinterface

interface etb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [etb_pkg::CFG_IDX_W-1:0]  index;
    logic [etb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/etb_queue.sv]
// ----------------------------------------------------------------------------
// etb_queue
// Show-ahead job queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "edge_truncated_neighbor_blur_top_macros.svh"

module etb_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  etb_pkg::t_job              i_job,
    input  logic                       i_pop,
    output logic [etb_pkg::QCNT_W-1:0] o_count,
    output logic                       o_head_valid,
    output etb_pkg::t_job              o_head
);

    localparam int PW = $clog2(etb_pkg::QUEUE_DEPTH);
    localparam logic [etb_pkg::QCNT_W-1:0] FULL = etb_pkg::QCNT_W'(etb_pkg::QUEUE_DEPTH);

    etb_pkg::t_job               r_mem [etb_pkg::QUEUE_DEPTH];
    logic [PW-1:0]               r_wr;
    logic [PW-1:0]               r_rd;
    logic [etb_pkg::QCNT_W-1:0]  r_count;
    logic [etb_pkg::QCNT_W-1:0]  n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + etb_pkg::QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - etb_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_count      = r_count;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    `ETB_ASSERT(a_push_has_room, i_clk, i_rst_n, i_push |-> (r_count != FULL))
    `ETB_ASSERT(a_pop_not_empty, i_clk, i_rst_n, i_pop |-> (r_count != '0))
    `ETB_ASSERT(a_count_tracks, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count != '0))

endmodule

[rtl/etb_front.sv]
// ----------------------------------------------------------------------------
// etb_front
// Geometry registers, raster position, line stores and 3x3 window; hands
// one job per pixel that triggers results to the queue.
// ----------------------------------------------------------------------------
module etb_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    etb_cfg_if.sink                    i_cfg,
    etb_pix_if.sink                    i_pix,
    input  logic [etb_pkg::QCNT_W-1:0] i_q_count,
    output logic                       o_push,
    output etb_pkg::t_job              o_job
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int QW1  = etb_pkg::QCNT_W + 1;
    localparam int RST_W = (MAX_COLS < 1024) ? MAX_COLS : 1024;
    localparam int RST_H = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
    localparam logic [CW-1:0] RST_LAST_COL = CW'(RST_W - 1);
    localparam logic [RW-1:0] RST_LAST_ROW = RW'(RST_H - 1);
    localparam logic [16:0]   MAXC = 17'(MAX_COLS);
    localparam logic [16:0]   MAXR = 17'(MAX_ROWS);

    // geometry, stored as last column / last row index
    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_last_row;
    logic [CW-1:0] cfg_last_col;
    logic [RW-1:0] cfg_last_row;
    logic [16:0]   cfg_w;
    logic [16:0]   cfg_h;
    logic          cfg_we;

    // raster position of the next pixel
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [1:0]    r_bank;

    logic          pix_acc;
    logic          at_last_col;
    logic          at_last_row;
    logic          row_nz;
    logic          col_nz;
    logic [31:0]   row32;
    logic [31:0]   col32;
    etb_pkg::t_pix pix_in;
    etb_pkg::t_job_info info_a;

    // stage B: line store read data is back
    logic               r_b_valid;
    etb_pkg::t_pix      r_b_pix;
    logic [1:0]         r_b_bank;
    etb_pkg::t_job_info r_b_info;
    etb_pkg::t_pix      r_rd [etb_pkg::NUM_BANKS];
    etb_pkg::t_pix      up1;
    etb_pkg::t_pix      up2;
    etb_pkg::t_win      r_win;
    etb_pkg::t_win      n_win;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;
    assign cfg_w       = 17'(i_cfg.data[10:0]);
    assign cfg_h       = 17'(i_cfg.data);

    always_comb begin
        if (cfg_w < 17'd2) begin
            cfg_last_col = CW'(1);
        end else if (cfg_w > MAXC) begin
            cfg_last_col = CW'(MAX_COLS - 1);
        end else begin
            cfg_last_col = CW'(cfg_w - 17'd1);
        end
        if (cfg_h < 17'd2) begin
            cfg_last_row = RW'(1);
        end else if (cfg_h > MAXR) begin
            cfg_last_row = RW'(MAX_ROWS - 1);
        end else begin
            cfg_last_row = RW'(cfg_h - 17'd1);
        end
    end

    // enough queue room for this pixel and the one in stage B
    assign i_pix.ready = (QW1'(i_q_count) + QW1'(r_b_valid)) < QW1'(etb_pkg::QUEUE_DEPTH);
    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign pix_in      = '{red: i_pix.red_in, green: i_pix.green_in, blue: i_pix.blue_in};

    assign at_last_col = (r_col == r_last_col);
    assign at_last_row = (r_row == r_last_row);
    assign row_nz      = (r_row != '0);
    assign col_nz      = (r_col != '0);
    assign row32       = 32'(r_row);
    assign col32       = 32'(r_col);

    always_comb begin
        info_a = '0;
        info_a.emit_mask[etb_pkg::EM_PREV_ROW_PREV_COL] = row_nz && col_nz;
        info_a.emit_mask[etb_pkg::EM_PREV_ROW_LAST]     = row_nz && at_last_col;
        info_a.emit_mask[etb_pkg::EM_LAST_ROW_PREV_COL] = at_last_row && col_nz;
        info_a.emit_mask[etb_pkg::EM_LAST_ROW_LAST]     = at_last_row && at_last_col;
        info_a.row_is_one = (r_row == RW'(1));
        info_a.col_is_one = (r_col == CW'(1));
        info_a.row        = row32[etb_pkg::ROW_OUT_W-1:0];
        info_a.col        = col32[etb_pkg::COL_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= RST_LAST_COL;
            r_last_row <= RST_LAST_ROW;
            r_col      <= '0;
            r_row      <= '0;
            r_bank     <= '0;
            r_b_valid  <= 1'b0;
        end else begin
            r_b_valid <= pix_acc;
            if (cfg_we && (i_cfg.index == etb_pkg::CFG_FRAME_WIDTH
                           || i_cfg.index == etb_pkg::CFG_FRAME_HEIGHT)) begin
                if (i_cfg.index == etb_pkg::CFG_FRAME_WIDTH) begin
                    r_last_col <= cfg_last_col;
                end else begin
                    r_last_row <= cfg_last_row;
                end
                r_col  <= '0;
                r_row  <= '0;
                r_bank <= '0;
            end else if (pix_acc) begin
                if (at_last_col) begin
                    r_col <= '0;
                    if (at_last_row) begin
                        r_row  <= '0;
                        r_bank <= '0;
                    end else begin
                        r_row  <= r_row + RW'(1);
                        r_bank <= (r_bank == 2'd2) ? 2'd0 : r_bank + 2'd1;
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // line stores: row r lives in bank r mod 3
    for (genvar g = 0; g < etb_pkg::NUM_BANKS; g++) begin : g_bank
        etb_pkg::t_pix r_mem [MAX_COLS];
        always_ff @(posedge i_clk) begin
            if (pix_acc) begin
                if (r_bank == 2'(g)) begin
                    r_mem[r_col] <= pix_in;
                end
                r_rd[g] <= r_mem[r_col];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_b_pix  <= pix_in;
            r_b_bank <= r_bank;
            r_b_info <= info_a;
        end
    end

    // pick the two older rows out of the bank reads
    always_comb begin
        case (r_b_bank)
            2'd0: begin
                up1 = r_rd[2];
                up2 = r_rd[1];
            end
            2'd1: begin
                up1 = r_rd[0];
                up2 = r_rd[2];
            end
            default: begin
                up1 = r_rd[1];
                up2 = r_rd[0];
            end
        endcase
    end

    always_comb begin
        for (int rr = 0; rr < 3; rr++) begin
            n_win[rr][0] = r_win[rr][1];
            n_win[rr][1] = r_win[rr][2];
        end
        n_win[0][2] = up2;
        n_win[1][2] = up1;
        n_win[2][2] = r_b_pix;
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_win <= n_win;
        end
    end

    assign o_push = r_b_valid && (r_b_info.emit_mask != '0);
    assign o_job  = '{win: n_win, info: r_b_info};

endmodule

[rtl/etb_back.sv]
// ----------------------------------------------------------------------------
// etb_back
// Walks the results of the queue head, one per cycle unless stalled,
// computes the truncated neighbor sums and holds them in the output register.
// ----------------------------------------------------------------------------
`include "edge_truncated_neighbor_blur_top_macros.svh"

module etb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  etb_pkg::t_job i_head,
    output logic          o_pop,
    etb_res_if.source     o_res
);

    localparam logic [etb_pkg::SUM_W-1:0]    SIDE_WEIGHT   = 12'd2;
    localparam logic [etb_pkg::WEIGHT_W-1:0] SIDE_WT       = 4'd2;
    localparam logic [etb_pkg::WEIGHT_W-1:0] WEIGHT_INNER  = 4'd12;
    localparam logic [etb_pkg::WEIGHT_W-1:0] WEIGHT_EDGE   = 4'd8;
    localparam logic [etb_pkg::WEIGHT_W-1:0] WEIGHT_CORNER = 4'd5;

    typedef struct packed {
        logic [etb_pkg::SUM_W-1:0]    red;
        logic [etb_pkg::SUM_W-1:0]    green;
        logic [etb_pkg::SUM_W-1:0]    blue;
        logic [etb_pkg::WEIGHT_W-1:0] weight;
    } t_sum;

    typedef struct packed {
        logic [etb_pkg::ROW_OUT_W-1:0] row;
        logic [etb_pkg::COL_OUT_W-1:0] col;
        t_sum                          sum;
        logic                          last;
    } t_result;

    function automatic t_sum neighbor_sum(etb_pkg::t_win v, logic top_ok, logic bot_ok,
                                          logic left_ok, logic right_ok);
        logic [2:0][7:0]  up;
        logic [2:0][7:0]  dn;
        logic [2:0][7:0]  lf;
        logic [2:0][7:0]  rt;
        logic [2:0][7:0]  ul;
        logic [2:0][7:0]  ur;
        logic [2:0][7:0]  dl;
        logic [2:0][7:0]  dr;
        logic [2:0][11:0] acc;
        t_sum             s;
        up = v[0][1];
        dn = v[2][1];
        lf = v[1][0];
        rt = v[1][2];
        ul = v[0][0];
        ur = v[0][2];
        dl = v[2][0];
        dr = v[2][2];
        for (int ch = 0; ch < 3; ch++) begin
            acc[ch] = SIDE_WEIGHT * (12'(up[ch] & {8{top_ok}}) + 12'(dn[ch] & {8{bot_ok}})
                                   + 12'(lf[ch] & {8{left_ok}}) + 12'(rt[ch] & {8{right_ok}}))
                    + 12'(ul[ch] & {8{top_ok & left_ok}}) + 12'(ur[ch] & {8{top_ok & right_ok}})
                    + 12'(dl[ch] & {8{bot_ok & left_ok}}) + 12'(dr[ch] & {8{bot_ok & right_ok}});
        end
        s.red    = acc[2];
        s.green  = acc[1];
        s.blue   = acc[0];
        s.weight = SIDE_WT * (4'(top_ok) + 4'(bot_ok) + 4'(left_ok) + 4'(right_ok))
                 + 4'(top_ok & left_ok) + 4'(top_ok & right_ok)
                 + 4'(bot_ok & left_ok) + 4'(bot_ok & right_ok);
        return s;
    endfunction

    logic [etb_pkg::NUM_EMIT-1:0] r_done;
    logic [etb_pkg::NUM_EMIT-1:0] remaining;
    logic [etb_pkg::NUM_EMIT-1:0] sel_bit;
    etb_pkg::t_emit               sel;
    logic                         is_last;
    logic                         advance;

    etb_pkg::t_win                    view;
    logic                             top_ok;
    logic                             bot_ok;
    logic                             left_ok;
    logic                             right_ok;
    logic [etb_pkg::ROW_OUT_W-1:0]    res_row;
    logic [etb_pkg::COL_OUT_W-1:0]    res_col;

    logic    r_out_valid;
    t_result r_out;

    assign remaining = i_head.info.emit_mask & ~r_done;

    always_comb begin
        if (remaining[etb_pkg::EM_PREV_ROW_PREV_COL]) begin
            sel = etb_pkg::EM_PREV_ROW_PREV_COL;
        end else if (remaining[etb_pkg::EM_PREV_ROW_LAST]) begin
            sel = etb_pkg::EM_PREV_ROW_LAST;
        end else if (remaining[etb_pkg::EM_LAST_ROW_PREV_COL]) begin
            sel = etb_pkg::EM_LAST_ROW_PREV_COL;
        end else begin
            sel = etb_pkg::EM_LAST_ROW_LAST;
        end
    end

    assign sel_bit = etb_pkg::NUM_EMIT'(1) << sel;
    assign is_last = ((remaining & ~sel_bit) == '0);
    assign advance = i_head_valid && (!r_out_valid || o_res.ready);
    assign o_pop   = advance && is_last;

    // re-center the window on the selected pixel and mask missing neighbors
    always_comb begin
        view     = i_head.win;
        top_ok   = 1'b1;
        bot_ok   = 1'b1;
        left_ok  = 1'b1;
        right_ok = 1'b1;
        res_row  = i_head.info.row;
        res_col  = i_head.info.col;
        case (sel)
            etb_pkg::EM_PREV_ROW_PREV_COL: begin
                top_ok  = !i_head.info.row_is_one;
                left_ok = !i_head.info.col_is_one;
                res_row = i_head.info.row - etb_pkg::ROW_OUT_W'(1);
                res_col = i_head.info.col - etb_pkg::COL_OUT_W'(1);
            end
            etb_pkg::EM_PREV_ROW_LAST: begin
                for (int rr = 0; rr < 3; rr++) begin
                    view[rr][0] = i_head.win[rr][1];
                    view[rr][1] = i_head.win[rr][2];
                end
                top_ok   = !i_head.info.row_is_one;
                right_ok = 1'b0;
                res_row  = i_head.info.row - etb_pkg::ROW_OUT_W'(1);
            end
            etb_pkg::EM_LAST_ROW_PREV_COL: begin
                view[0] = i_head.win[1];
                view[1] = i_head.win[2];
                bot_ok  = 1'b0;
                left_ok = !i_head.info.col_is_one;
                res_col = i_head.info.col - etb_pkg::COL_OUT_W'(1);
            end
            etb_pkg::EM_LAST_ROW_LAST: begin
                view[0][0] = i_head.win[1][1];
                view[0][1] = i_head.win[1][2];
                view[1][0] = i_head.win[2][1];
                view[1][1] = i_head.win[2][2];
                bot_ok     = 1'b0;
                right_ok   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_done      <= is_last ? '0 : (r_done | sel_bit);
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.row  <= res_row;
            r_out.col  <= res_col;
            r_out.sum  <= neighbor_sum(view, top_ok, bot_ok, left_ok, right_ok);
            r_out.last <= is_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_row      = r_out.row;
    assign o_res.out_col      = r_out.col;
    assign o_res.red_sum      = r_out.sum.red;
    assign o_res.green_sum    = r_out.sum.green;
    assign o_res.blue_sum     = r_out.sum.blue;
    assign o_res.total_weight = r_out.sum.weight;
    assign o_res.last_of_run  = r_out.last;

    `ETB_ASSERT(a_weight_legal, i_clk, i_rst_n, r_out_valid |-> (r_out.sum.weight == WEIGHT_INNER || r_out.sum.weight == WEIGHT_EDGE || r_out.sum.weight == WEIGHT_CORNER))
    `ETB_ASSERT(a_col0_truncated, i_clk, i_rst_n, (r_out_valid && r_out.col == '0) |-> (r_out.sum.weight != WEIGHT_INNER))
    `ETB_ASSERT(a_head_has_work, i_clk, i_rst_n, i_head_valid |-> (remaining != '0))

endmodule

[rtl/edge_truncated_neighbor_blur_top.sv]
// ----------------------------------------------------------------------------
// edge_truncated_neighbor_blur_top
// Path: a pixel passes the line store read (stage B), the queue and the
//   output register; later results one per cycle while o_res is ready.
// Throughput: one pixel per cycle while the queue has room; results are set
//   by the back end; row-end and last-row pixels yield up to 4 results.
// Reset: synchronous active low; geometry returns to 1024 x 1024 (clamped to
//   MAX_COLS/MAX_ROWS), position to (0,0); line stores are not cleared.
// ----------------------------------------------------------------------------
module edge_truncated_neighbor_blur_top #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    etb_cfg_if.sink   i_cfg,
    etb_pix_if.sink   i_pix,
    etb_res_if.source o_res
);

    // Front end: config, raster position, line stores, 3x3 window.
    // It forms one job per pixel that closes at least one neighborhood.
    logic                       push;
    etb_pkg::t_job              push_job;
    logic [etb_pkg::QCNT_W-1:0] q_count;

    // Back end side of the queue
    logic                       head_valid;
    etb_pkg::t_job              head_job;
    logic                       pop;

    etb_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_pix     (i_pix),
        .i_q_count (q_count),
        .o_push    (push),
        .o_job     (push_job)
    );

    // Short queue decouples pixel intake from result delivery; it soaks up
    // the extra results at row ends and in the last row.
    etb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .i_pop        (pop),
        .o_count      (q_count),
        .o_head_valid (head_valid),
        .o_head       (head_job)
    );

    // Back end: one transaction per cycle into the output register while o_res
    // is not stalled; the last result of each job carries last_of_run.
    etb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule
